// ===== rtl/set_assoc_lru_cache_model_top_defines.svh =====
`ifndef SET_ASSOC_LRU_CACHE_MODEL_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/salc_pkg.sv =====
package salc_pkg;

   localparam int ADDR_W       = 64;
   localparam int KIND_W       = 2;
   localparam int TAG_W        = 64;
   localparam int STAMP_W      = 32;
   localparam int COUNT_W      = 32;
   localparam int SHIFT_W      = 7;
   localparam int WAYS_CNT_W   = 5;
   localparam int SET_BITS_W   = 3;
   localparam int BLOCK_BITS_W = 6;
   localparam int WAYS_W       = 4;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 6;
   localparam int RSP_FIELDS_W = 3 + 3 * COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   localparam logic [SET_BITS_W-1:0]   SET_BITS_RESET   = 3'd4;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RESET = 6'd4;
   localparam logic [WAYS_W-1:0]       WAYS_RESET       = 4'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_STORE  = 2'd1,
      KIND_MODIFY = 2'd2
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_BLOCK_BITS = 2'd1,
      CSR_WAYS       = 2'd2
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic decide;
      logic commit;
   } salc_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } salc_status_type;

endpackage

// ===== rtl/salc_ctrl.sv =====
`include "set_assoc_lru_cache_model_top_defines.svh"

module salc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  salc_pkg::salc_status_type  status,
   output salc_pkg::salc_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   assign req_tready = ready_ff;

   always_comb begin
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.load   = req_tvalid && ready_ff;
      cmd.decide = (state_ff == ST_LOOKUP);
      cmd.commit = (state_ff == ST_WRITE) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_LOOKUP;
               ready_in = 1'b0;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   `SALC_ASSERT_NOW(a_ready_only_idle, clock, reset, ready_ff, state_ff == ST_IDLE, "ready outside idle")
   `SALC_ASSERT_NEXT(a_accept_to_lookup, clock, reset, cmd.load, state_ff == ST_LOOKUP, "accept did not start lookup")
   `SALC_ASSERT_NEXT(a_write_holds, clock, reset, (state_ff == ST_WRITE) && !status.out_free, state_ff == ST_WRITE, "write left while output busy")

endmodule

// ===== rtl/salc_dp.sv =====
`include "set_assoc_lru_cache_model_top_defines.svh"

module salc_dp #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  salc_pkg::salc_cmd_type                 cmd,
   output salc_pkg::salc_status_type              status,
   input  logic [salc_pkg::SET_BITS_W-1:0]        set_bits,
   input  logic [salc_pkg::BLOCK_BITS_W-1:0]      block_bits,
   input  logic [salc_pkg::WAYS_W-1:0]            ways_in_use,
   input  logic [salc_pkg::ADDR_W-1:0]            req_address,
   input  logic [salc_pkg::KIND_W-1:0]            req_kind,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [salc_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SET_W    = MAX_SET_BITS;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   localparam int TAG_W   = salc_pkg::TAG_W;
   localparam int STAMP_W = salc_pkg::STAMP_W;
   localparam int COUNT_W = salc_pkg::COUNT_W;
   localparam int SHIFT_W = salc_pkg::SHIFT_W;
   localparam int WCNT_W  = salc_pkg::WAYS_CNT_W;

   // Tag store: one row per set, all ways side by side.
   logic [MAX_WAYS-1:0]              valid_mem [NUM_SETS];
   logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_mem   [NUM_SETS];
   logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp_mem [NUM_SETS];

   logic [MAX_WAYS-1:0]              rd_valid_ff;
   logic [MAX_WAYS-1:0][TAG_W-1:0]   rd_tag_ff;
   logic [MAX_WAYS-1:0][STAMP_W-1:0] rd_stamp_ff;

   logic [SET_W-1:0]   clr_ff;
   logic [SET_W-1:0]   set_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [salc_pkg::KIND_W-1:0] kind_ff;

   logic               dec_hit_ff;
   logic               dec_evict_ff;
   logic [WAY_W-1:0]   dec_way_ff;

   logic [STAMP_W-1:0] clock_ff;
   logic [COUNT_W-1:0] hit_total_ff;
   logic [COUNT_W-1:0] miss_total_ff;
   logic [COUNT_W-1:0] evict_total_ff;

   logic                              rsp_valid_ff;
   logic [salc_pkg::RSP_FIELDS_W-1:0] rsp_data_ff;

   // Address split.
   logic [SHIFT_W-1:0]         sb_eff;
   logic [SHIFT_W-1:0]         total;
   logic [salc_pkg::ADDR_W-1:0] shifted;
   logic [SET_W-1:0]           set_mask;
   logic [SET_W-1:0]           set_idx;
   logic [TAG_W-1:0]           tag_c;
   logic [WCNT_W-1:0]          ways_eff;
   logic [MAX_WAYS-1:0]        way_en;

   always_comb begin
      sb_eff = (SHIFT_W'(set_bits) > SHIFT_W'(MAX_SET_BITS)) ?
               SHIFT_W'(MAX_SET_BITS) : SHIFT_W'(set_bits);
      total   = sb_eff + SHIFT_W'(block_bits);
      shifted = req_address >> block_bits;
      for (int i = 0; i < SET_W; i++) begin
         set_mask[i] = SHIFT_W'(i) < sb_eff;
      end
      set_idx = shifted[SET_W-1:0] & set_mask;
      // A shift of 64 or more clears the tag.
      tag_c   = req_address >> total;

      if (ways_in_use == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (WCNT_W'(ways_in_use) > WCNT_W'(MAX_WAYS)) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_in_use);
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_en[w] = WCNT_W'(w) < ways_eff;
      end
   end

   // Lookup over the row read for this item.
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] free_vec;
   logic [MAX_WAYS-1:0] lru_vec;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    free_way;
   logic [WAY_W-1:0]    lru_way;
   logic [WAY_W-1:0]    victim;
   logic                beats;

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      lru_way  = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         hit_vec[w]  = way_en[w] && rd_valid_ff[w] && (rd_tag_ff[w] == tag_ff);
         free_vec[w] = way_en[w] && !rd_valid_ff[w];
         // A way is the oldest if it is strictly older than every lower way
         // and no younger than every higher way.
         beats = way_en[w];
         for (int v = 0; v < MAX_WAYS; v++) begin
            if (v != w && way_en[v]) begin
               if (v < w) begin
                  beats = beats && (rd_stamp_ff[w] < rd_stamp_ff[v]);
               end else begin
                  beats = beats && (rd_stamp_ff[w] <= rd_stamp_ff[v]);
               end
            end
         end
         lru_vec[w] = beats;
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (free_vec[w]) begin
            free_way = WAY_W'(w);
         end
         if (lru_vec[w]) begin
            lru_way = WAY_W'(w);
         end
      end
      victim = (|free_vec) ? free_way : lru_way;
   end

   // Write-back values.
   logic [STAMP_W-1:0]               clock_in;
   logic [MAX_WAYS-1:0]              valid_new;
   logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_new;
   logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp_new;
   logic                             modify;
   logic [COUNT_W-1:0]               hit_total_in;
   logic [COUNT_W-1:0]               miss_total_in;
   logic [COUNT_W-1:0]               evict_total_in;
   logic [SET_W-1:0]                 wr_addr;
   logic [MAX_WAYS-1:0]              wr_valid;

   always_comb begin
      clock_in   = clock_ff + STAMP_W'(1);
      valid_new  = rd_valid_ff | (MAX_WAYS'(1) << dec_way_ff);
      tag_new    = rd_tag_ff;
      tag_new[dec_way_ff] = tag_ff;
      stamp_new  = rd_stamp_ff;
      stamp_new[dec_way_ff] = clock_in;
      modify     = (kind_ff == salc_pkg::KIND_MODIFY);
      hit_total_in   = hit_total_ff + COUNT_W'(dec_hit_ff) + COUNT_W'(modify);
      miss_total_in  = miss_total_ff + COUNT_W'(!dec_hit_ff);
      evict_total_in = evict_total_ff + COUNT_W'(dec_evict_ff);
      wr_addr    = cmd.clear ? clr_ff : set_ff;
      wr_valid   = cmd.clear ? '0 : valid_new;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear || cmd.commit) begin
         valid_mem[wr_addr] <= wr_valid;
      end
      if (cmd.commit) begin
         tag_mem[set_ff]   <= tag_new;
         stamp_mem[set_ff] <= stamp_new;
      end
      if (cmd.load) begin
         rd_valid_ff <= valid_mem[set_idx];
         rd_tag_ff   <= tag_mem[set_idx];
         rd_stamp_ff <= stamp_mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         set_ff  <= set_idx;
         tag_ff  <= tag_c;
         kind_ff <= req_kind;
      end
      if (cmd.decide) begin
         dec_hit_ff   <= |hit_vec;
         dec_way_ff   <= (|hit_vec) ? hit_way : victim;
         dec_evict_ff <= !(|hit_vec) && rd_valid_ff[victim];
      end
      if (cmd.commit) begin
         rsp_data_ff <= {evict_total_in, miss_total_in, hit_total_in,
                         modify, dec_evict_ff, dec_hit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff         <= '0;
         clock_ff       <= '0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + SET_W'(1);
         end
         if (cmd.commit) begin
            clock_ff       <= clock_in;
            hit_total_ff   <= hit_total_in;
            miss_total_ff  <= miss_total_in;
            evict_total_ff <= evict_total_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   assign status.clear_last = (clr_ff == '1);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = {{salc_pkg::RSP_PAD_W{1'b0}}, rsp_data_ff};

   `SALC_ASSERT_NOW(a_hit_no_evict, clock, reset, cmd.commit, !(dec_hit_ff && dec_evict_ff), "hit marked as eviction")
   `SALC_ASSERT_NEXT(a_miss_counted, clock, reset, cmd.commit && !dec_hit_ff, miss_total_ff == $past(miss_total_ff) + 1, "miss total not advanced")
   `SALC_ASSERT_NEXT(a_result_shown, clock, reset, cmd.commit, rsp_valid_ff, "committed item has no result")

endmodule

// ===== rtl/set_assoc_lru_cache_model_top.sv =====
// Tag store of a set-associative cache with least-recently-used replacement.
// Each item on the req_ channel is one access (load, store or modify) to a
// byte address; each access returns exactly one item on the rsp_ channel with
// the hit and eviction flags, a second-hit flag for modify accesses and the
// running hit, miss and eviction totals, which wrap at 32 bits. The address
// is split by the set_bits and block_bits registers, and only the first
// ways_in_use ways of each set are searched and filled. On a miss the
// lowest-numbered invalid way is filled first, otherwise the way with the
// oldest age stamp. An access runs as follows: the accepting edge reads
// the whole set row from the single-ported tag store, the lookup state compares
// every way in parallel and picks the victim, and the write state writes the row
// back and loads the result register. A new item is accepted in the cycle
// after the write-back, so the block takes no new item while one is in
// flight; a result waiting in the output register holds off only the
// write-back of the next item. After reset the block runs a clearing pass
// over every set of the tag store and accepts no item until it ends.
// Configuration registers may be written at any time the block is idle; the
// store is not cleared by a configuration change.
module set_assoc_lru_cache_model_top #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Access items.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [salc_pkg::ADDR_W-1:0]          req_tdata,   // [63:0] address
   input  logic [salc_pkg::KIND_W-1:0]          req_tuser,   // [1:0] req_type
   // Result items.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] hit, [1] eviction, [2] second_hit, [34:3] hit_count,
   // [66:35] miss_count, [98:67] eviction_count, upper bits zero
   output logic [salc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Configuration writes.
   input  logic                                 csr_we,
   input  logic [salc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [salc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [salc_pkg::SET_BITS_W-1:0]   set_bits_ff;
   logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_ff;
   logic [salc_pkg::WAYS_W-1:0]       ways_ff;

   salc_pkg::salc_cmd_type    cmd;
   salc_pkg::salc_status_type status;

   // Configuration registers. Writes to an index past the last register
   // are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= salc_pkg::SET_BITS_RESET;
         block_bits_ff <= salc_pkg::BLOCK_BITS_RESET;
         ways_ff       <= salc_pkg::WAYS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            salc_pkg::CSR_SET_BITS: begin
               set_bits_ff <= csr_wdata[salc_pkg::SET_BITS_W-1:0];
            end
            salc_pkg::CSR_BLOCK_BITS: begin
               block_bits_ff <= csr_wdata[salc_pkg::BLOCK_BITS_W-1:0];
            end
            salc_pkg::CSR_WAYS: begin
               ways_ff <= csr_wdata[salc_pkg::WAYS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The controller sequences clear, read, compare and write-back.
   salc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns the tag store, the counters and the result register.
   salc_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .set_bits    (set_bits_ff),
      .block_bits  (block_bits_ff),
      .ways_in_use (ways_ff),
      .req_address (req_tdata),
      .req_kind    (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

   // Geometry of the instance under test. The predictor below uses the same numbers.
   localparam int unsigned SET_BITS_MAX = 6;
   localparam int unsigned WAY_COUNT    = 8;
   localparam int unsigned LINE_COUNT   = (1 << SET_BITS_MAX) * WAY_COUNT;

   // A run with no accepted item for this many cycles is taken as a hang. The slowest
   // correct stretch is the clearing pass after reset or a long receiver stall, so this is
   // many times over.
   localparam int unsigned STALL_LIMIT = 2000;

   typedef logic [salc_pkg::KIND_W-1:0]     kind_field_type;
   typedef logic [salc_pkg::CSR_DATA_W-1:0] csr_word_type;

   // The kind code that the package does not name. The block treats it as a load.
   localparam kind_field_type KIND_UNKNOWN = 2'd3;

   localparam int unsigned FIXED_PHASES  = 6;
   localparam int unsigned RANDOM_PHASES = 5;
   localparam int unsigned PHASE_ITEMS   = 104;
   // This phase runs with neither side idling, which gives one long back-to-back stretch.
   localparam int unsigned STEADY_PHASE  = 3;

   // One result item, unpacked from rsp_tdata.
   typedef struct packed {
      logic        hit;
      logic        eviction;
      logic        second_hit;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] eviction_count;
   } access_outcome_type;

   // One row of the directed table. Where known is set, the expected result is the
   // typed-in one. Otherwise the predictor supplies it.
   typedef struct {
      kind_field_type    kind;
      logic [63:0]       addr;
      bit                known;
      bit                hit;
      bit                eviction;
      bit                second_hit;
      int unsigned       hits;
      int unsigned       misses;
      int unsigned       evictions;
   } directed_row_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_tvalid;
   logic                                  req_tready;
   logic [salc_pkg::ADDR_W-1:0]           req_tdata;
   kind_field_type                        req_tuser;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [salc_pkg::RSP_TDATA_W-1:0]      rsp_tdata;
   logic                                  csr_we;
   logic [salc_pkg::CSR_ADDR_W-1:0]       csr_addr;
   csr_word_type                          csr_wdata;

   // The predictor's copy of the configuration and of the tag store.
   logic [salc_pkg::SET_BITS_W-1:0]       set_bits_q;
   logic [salc_pkg::BLOCK_BITS_W-1:0]     block_bits_q;
   logic [salc_pkg::WAYS_W-1:0]           ways_q;
   bit                        held_valid [LINE_COUNT];
   logic [63:0]               held_tag   [LINE_COUNT];
   logic [31:0]               held_stamp [LINE_COUNT];
   logic [31:0]               access_tick;
   logic [31:0]               total_hits;
   logic [31:0]               total_misses;
   logic [31:0]               total_evictions;

   // Outcomes of accepted accesses whose result items have not come back yet, oldest first.
   access_outcome_type        pending_outcomes [$];

   // The random part draws tags from a small pool per phase, so that the sets fill up,
   // hit again and are forced into LRU replacement.
   logic [63:0]               tag_pool [16];
   int unsigned               pool_size;

   bit                        steady;
   int unsigned               mismatches;
   int unsigned               quiet_cycles;

   // The directed part runs with the reset split: 4 offset bits, 4 set bits, one way.
   // So the set index is address bits [7:4] and the tag is bits [63:8].
   directed_row_type directed_rows [20] = '{
      '{salc_pkg::KIND_LOAD,   64'h0000_0000_0000_0000, 1, 0, 0, 0, 0, 1, 0},
      '{salc_pkg::KIND_LOAD,   64'h0000_0000_0000_000F, 1, 1, 0, 0, 1, 1, 0},
      '{salc_pkg::KIND_STORE,  64'h0000_0000_0000_0000, 1, 1, 0, 0, 2, 1, 0},
      '{salc_pkg::KIND_MODIFY, 64'h0000_0000_0000_0000, 1, 1, 0, 1, 4, 1, 0},
      '{salc_pkg::KIND_LOAD,   64'h0000_0000_0000_0100, 1, 0, 1, 0, 4, 2, 1},
      '{KIND_UNKNOWN,          64'h0000_0000_0000_0100, 1, 1, 0, 0, 5, 2, 1},
      '{salc_pkg::KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 1, 6, 3, 1},
      '{salc_pkg::KIND_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0, 0, 7, 3, 1},
      '{salc_pkg::KIND_LOAD,   64'h8000_0000_0000_00F0, 1, 0, 1, 0, 7, 4, 2},
      '{salc_pkg::KIND_LOAD,   64'hFFFF_FFFF_FFFF_FF0F, 1, 0, 1, 0, 7, 5, 3},
      '{salc_pkg::KIND_MODIFY, 64'h0000_0000_0000_0100, 1, 0, 1, 1, 8, 6, 4},
      '{salc_pkg::KIND_STORE,  64'h5555_5555_5555_5555, 1, 0, 0, 0, 8, 7, 4},
      '{salc_pkg::KIND_LOAD,   64'hAAAA_AAAA_AAAA_AAAA, 1, 0, 0, 0, 8, 8, 4},
      '{salc_pkg::KIND_LOAD,   64'h5555_5555_5555_5555, 1, 1, 0, 0, 9, 8, 4},
      '{KIND_UNKNOWN,          64'h1234_5678_9ABC_DEF0, 0, 0, 0, 0, 0, 0, 0},
      '{salc_pkg::KIND_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0, 0, 0},
      '{salc_pkg::KIND_STORE,  64'h0000_0001_0000_0050, 0, 0, 0, 0, 0, 0, 0},
      '{salc_pkg::KIND_LOAD,   64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
      '{salc_pkg::KIND_MODIFY, 64'h0000_0000_0000_00FF, 0, 0, 0, 0, 0, 0, 0},
      '{salc_pkg::KIND_STORE,  64'h0000_0000_0000_0000, 0, 0, 0, 0, 0, 0, 0}
   };

   // Register settings of the fixed phases, written as {set_bits, block_bits, ways_in_use}.
   // They cover a single set with no offset and a 64-bit tag, the widest split where the
   // tag vanishes and ways beyond the built count, a one-bit offset with all eight ways,
   // and a few mid-range splits. The random phases that follow also put junk in the upper
   // bits of the narrower registers.
   csr_word_type fixed_settings [FIXED_PHASES][3] = '{
      '{6'd0, 6'd0,  6'd0},
      '{6'd7, 6'd63, 6'd15},
      '{6'd6, 6'd1,  6'd8},
      '{6'd1, 6'd32, 6'd2},
      '{6'd2, 6'd58, 6'd3},
      '{6'd5, 6'd3,  6'd4}
   };

   set_assoc_lru_cache_model_top #(
      .MAX_SET_BITS (SET_BITS_MAX),
      .MAX_WAYS     (WAY_COUNT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Set bits beyond the built count are clipped to it.
   function automatic int unsigned active_set_bits();
      return (set_bits_q > SET_BITS_MAX) ? SET_BITS_MAX : 32'(set_bits_q);
   endfunction

   // A way count of zero acts as one. A count above the built ways is clipped.
   function automatic int unsigned active_ways();
      if (ways_q == 0)
         return 1;
      return (ways_q > WAY_COUNT) ? WAY_COUNT : 32'(ways_q);
   endfunction

   // Applies one access to the predictor's tag store and returns the result item that
   // the block must produce for it.
   function automatic access_outcome_type predict_access(kind_field_type kind,
                                                         logic [63:0] addr);
      int unsigned        sb;
      int unsigned        total;
      int unsigned        ways;
      int unsigned        base;
      int unsigned        w;
      int unsigned        victim;
      logic [63:0]        set_idx;
      logic [63:0]        tag;
      bit                 found;
      access_outcome_type outcome;
      sb      = active_set_bits();
      total   = sb + 32'(block_bits_q);
      ways    = active_ways();
      set_idx = (addr >> block_bits_q) & ((64'd1 << sb) - 64'd1);
      tag     = (total >= 64) ? 64'd0 : (addr >> total);
      base    = 32'(set_idx) * WAY_COUNT;
      found   = 1'b0;
      victim  = 0;
      for (w = 0; w < ways; w++) begin
         if (!found && held_valid[base + w] && held_tag[base + w] == tag) begin
            found  = 1'b1;
            victim = w;
         end
      end
      access_tick = access_tick + 32'd1;
      outcome     = '0;
      outcome.hit = found;
      if (found) begin
         held_stamp[base + victim] = access_tick;
         total_hits = total_hits + 32'd1;
      end else begin
         // The lowest invalid way wins. With none, the oldest stamp wins, and the
         // lowest way on a tie.
         for (w = ways; w > 0; w--) begin
            if (!held_valid[base + w - 1]) begin
               victim = w - 1;
               found  = 1'b1;
            end
         end
         if (!found) begin
            victim = 0;
            for (w = 1; w < ways; w++) begin
               if (held_stamp[base + w] < held_stamp[base + victim])
                  victim = w;
            end
         end
         outcome.eviction = held_valid[base + victim];
         held_valid[base + victim] = 1'b1;
         held_tag[base + victim]   = tag;
         held_stamp[base + victim] = access_tick;
         total_misses = total_misses + 32'd1;
         if (outcome.eviction)
            total_evictions = total_evictions + 32'd1;
      end
      // The store half of a modify always hits.
      if (kind == salc_pkg::KIND_MODIFY) begin
         outcome.second_hit = 1'b1;
         total_hits = total_hits + 32'd1;
      end
      outcome.hit_count      = total_hits;
      outcome.miss_count     = total_misses;
      outcome.eviction_count = total_evictions;
      return outcome;
   endfunction

   // Builds a random address under the current split. Most addresses land in the low
   // few sets with a tag from the pool. The rest are fully random.
   function automatic logic [63:0] pick_address();
      logic [63:0] addr;
      logic [63:0] set_part;
      logic [63:0] tag_part;
      int unsigned total;
      addr = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 15)
         return addr;
      total    = active_set_bits() + 32'(block_bits_q);
      set_part = 64'($urandom_range(0, 3));
      set_part = set_part & ((64'd1 << active_set_bits()) - 64'd1);
      tag_part = (total >= 64) ? 64'd0 : tag_pool[$urandom_range(0, pool_size - 1)];
      addr = (addr & ((64'd1 << block_bits_q) - 64'd1)) | (set_part << block_bits_q)
             | (tag_part << total);
      return addr;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("tb: mismatch in %s at %0t ns: got %0h, expected %0h",
               what, $time, got, want);
      mismatches++;
   endtask

   // Offers one access item and returns at the edge where it is accepted. Outside the
   // steady phase it first idles for a random number of cycles.
   task automatic issue_access(kind_field_type kind, logic [63:0] addr);
      while (!steady && $urandom_range(0, 99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= addr;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // Stops offering items and waits until every outstanding result item has come back.
   // Each access returns exactly one result, so the block is idle from then on.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(salc_pkg::csr_index_type index, csr_word_type value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      // Each register keeps only its own low bits of the write data.
      case (index)
         salc_pkg::CSR_SET_BITS: begin
            set_bits_q = value[salc_pkg::SET_BITS_W-1:0];
         end
         salc_pkg::CSR_BLOCK_BITS: begin
            block_bits_q = value[salc_pkg::BLOCK_BITS_W-1:0];
         end
         salc_pkg::CSR_WAYS: begin
            ways_q = value[salc_pkg::WAYS_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // Receiver. It takes result items with random stalls and checks each item against
   // the oldest outstanding outcome. Sampling at the edge sees the values from before the
   // edge, the same values the block sees.
   always @(posedge clock) begin : rsp_check
      access_outcome_type got;
      access_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit            = rsp_tdata[0];
         got.eviction       = rsp_tdata[1];
         got.second_hit     = rsp_tdata[2];
         got.hit_count      = rsp_tdata[34:3];
         got.miss_count     = rsp_tdata[66:35];
         got.eviction_count = rsp_tdata[98:67];
         if (rsp_tdata[salc_pkg::RSP_TDATA_W-1:salc_pkg::RSP_FIELDS_W] != '0)
            report_mismatch("tdata padding",
                            64'(rsp_tdata[salc_pkg::RSP_TDATA_W-1:salc_pkg::RSP_FIELDS_W]),
                            64'd0);
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result item", 64'(got.hit_count), 64'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.hit !== want.hit)
               report_mismatch("hit", 64'(got.hit), 64'(want.hit));
            if (got.eviction !== want.eviction)
               report_mismatch("eviction", 64'(got.eviction), 64'(want.eviction));
            if (got.second_hit !== want.second_hit)
               report_mismatch("second_hit", 64'(got.second_hit), 64'(want.second_hit));
            if (got.hit_count !== want.hit_count)
               report_mismatch("hit_count", 64'(got.hit_count), 64'(want.hit_count));
            if (got.miss_count !== want.miss_count)
               report_mismatch("miss_count", 64'(got.miss_count), 64'(want.miss_count));
            if (got.eviction_count !== want.eviction_count)
               report_mismatch("eviction_count", 64'(got.eviction_count),
                               64'(want.eviction_count));
         end
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= 36);
   end

   // Watchdog. Any accepted item on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      access_outcome_type outcome;
      logic [63:0]        addr;
      kind_field_type     kind;
      csr_word_type       setting [3];
      int unsigned        phase;
      int unsigned        n;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= salc_pkg::KIND_LOAD;
      csr_we     <= 1'b0;
      csr_addr   <= salc_pkg::CSR_SET_BITS;
      csr_wdata  <= '0;
      steady       = 1'b0;

      // The predictor starts from the reset state: registers at their reset values and
      // an empty store.
      set_bits_q      = salc_pkg::SET_BITS_RESET;
      block_bits_q    = salc_pkg::BLOCK_BITS_RESET;
      ways_q          = salc_pkg::WAYS_RESET;
      access_tick     = '0;
      total_hits      = '0;
      total_misses    = '0;
      total_evictions = '0;
      foreach (held_valid[i]) begin
         held_valid[i] = 1'b0;
         held_tag[i]   = '0;
         held_stamp[i] = '0;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset configuration. The block runs its clearing pass
      // first, and the first item simply waits for req_tready.
      foreach (directed_rows[i]) begin
         issue_access(directed_rows[i].kind, directed_rows[i].addr);
         outcome = predict_access(directed_rows[i].kind, directed_rows[i].addr);
         if (directed_rows[i].known) begin
            outcome.hit            = directed_rows[i].hit;
            outcome.eviction       = directed_rows[i].eviction;
            outcome.second_hit     = directed_rows[i].second_hit;
            outcome.hit_count      = directed_rows[i].hits;
            outcome.miss_count     = directed_rows[i].misses;
            outcome.eviction_count = directed_rows[i].evictions;
         end
         pending_outcomes.push_back(outcome);
      end

      // Fixed and random phases. Before each phase the sender holds back until every result item has
      // come back, and only then are the registers written. The store is not cleared, so
      // lines filled under one split stay in place for the next one.
      for (phase = 0; phase < FIXED_PHASES + RANDOM_PHASES; phase++) begin
         drain_results();
         if (phase < FIXED_PHASES) begin
            setting = fixed_settings[phase];
         end else begin
            setting[0] = csr_word_type'($urandom_range(0, 63));
            setting[1] = csr_word_type'($urandom_range(0, 36));
            setting[2] = csr_word_type'($urandom_range(0, 63));
         end
         write_register(salc_pkg::CSR_SET_BITS, setting[0]);
         write_register(salc_pkg::CSR_BLOCK_BITS, setting[1]);
         write_register(salc_pkg::CSR_WAYS, setting[2]);
         csr_we <= 1'b0;

         pool_size = active_ways() + $urandom_range(0, 3);
         foreach (tag_pool[i])
            tag_pool[i] = {$urandom, $urandom};
         steady = (phase == STEADY_PHASE);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            kind = kind_field_type'($urandom_range(0, 3));
            addr = pick_address();
            issue_access(kind, addr);
            pending_outcomes.push_back(predict_access(kind, addr));
         end
      end

      // Let the last result items drain, then allow a few cycles for any stray item.
      steady = 1'b0;
      drain_results();
      repeat (12) @(posedge clock);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
